// File: hdl/urea_pkg.sv
// ----------------------------------------------------------------------------
// urea_pkg - shared types and constants of the echo range averager
// Field widths, channel and window sizing, divide-by-window reciprocal and
// configuration register codes.
// ----------------------------------------------------------------------------
package urea_pkg;

  // sizing
  localparam int CHANNELS     = 6;
  localparam int WINDOW_DEPTH = 4;
  localparam int COUNTER_BITS = 16;

  // fixed field widths
  localparam int CH_W      = 3;
  localparam int CNT_IN_W  = 16;
  localparam int DIST_W    = 18;
  localparam int SCALE_W   = 32;
  localparam int FRAC_DROP = 16;

  // derived widths
  localparam int CH_AW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int WID_W   = COUNTER_BITS + 1;
  localparam int PROD_W  = WID_W + SCALE_W;
  localparam int RAW_W   = PROD_W - FRAC_DROP;
  localparam int ROW_W   = WINDOW_DEPTH * DIST_W;
  localparam int DIV_L   = $clog2(WINDOW_DEPTH);
  localparam int SUM_W   = DIST_W + DIV_L;

  // sum / WINDOW_DEPTH as (sum * DIV_M) >> DIV_SH, exact for sum < 2**SUM_W
  localparam int DIV_SH  = SUM_W + DIV_L;
  localparam int DIV_MW  = SUM_W + 2;
  localparam longint unsigned DIV_M =
    ((64'd1 << DIV_SH) + longint'(WINDOW_DEPTH) - 64'd1) / longint'(WINDOW_DEPTH);
  localparam int DIV_PW  = SUM_W + DIV_MW;

  // configuration registers
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TICK_SCALE   = 1'b0,
    REG_MAX_DISTANCE = 1'b1
  } cfg_reg_e;

  localparam logic [SCALE_W-1:0] TICK_SCALE_RST   = 32'd746950;
  localparam logic [DIST_W-1:0]  MAX_DISTANCE_RST = 18'd196608;

  // input commands
  localparam logic CMD_EDGE   = 1'b0;
  localparam logic CMD_REFILL = 1'b1;

  typedef struct packed {
    logic                command;
    logic [CH_W-1:0]     channel;
    logic [CNT_IN_W-1:0] capture_count;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0]   out_channel;
    logic              distance_valid;
    logic [DIST_W-1:0] distance;
    logic              expect_falling;
  } out_item_t;

endpackage

// File: hdl/urea_ram.sv
// ----------------------------------------------------------------------------
// urea_ram - generic simple dual-port RAM
// One write port, one read port, read data registered and held while the
// read enable is low.
// ----------------------------------------------------------------------------
module urea_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/ultrasonic_echo_range_averager_unit.sv
// ----------------------------------------------------------------------------
// ultrasonic_echo_range_averager_unit - multi-channel echo ranger with
// moving-average filter
// Pairs capture events per channel into a pulse width, scales it to Q2.16
// metres, saturates it and averages it over a per-channel window.
// ----------------------------------------------------------------------------
// One transaction is accepted every cycle while the output is not stalled,
// and each produces exactly one result transaction, in order. The pipeline
// reads the first-edge count memory, forms the width, multiplies by
// tick_scale, saturates, does a read-modify-write of the channel's window
// row in the window memory and divides the window sum by the depth. A stall
// on the result channel freezes the whole pipeline and is passed back to
// the input as in_stall. Window rows read as zero until a channel's first
// distance is written; no clearing pass is needed after reset.
// Configuration writes are always ready and take effect at once.
module ultrasonic_echo_range_averager_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  urea_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output urea_pkg::out_item_t           out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [urea_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [urea_pkg::CFG_DATA_W-1:0] cfg_data
);

  import urea_pkg::*;

  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic            sec;      // second edge: produces a distance
    logic            refill;   // fill the window instead of averaging
    logic            falling;
  } tag_t;

  // configuration
  logic [SCALE_W-1:0] tick_scale_r;
  logic [DIST_W-1:0]  max_distance_r;

  // per-channel edge state
  logic [CHANNELS-1:0] waiting_r;
  logic [CHANNELS-1:0] pending_r;
  logic [CHANNELS-1:0] row_valid_r;

  // pipeline
  logic                    adv;
  logic                    acc;
  logic                    s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r;
  tag_t                    s1_tag_r, s2_tag_r, s3_tag_r, s4_tag_r, s5_tag_r;
  logic [COUNTER_BITS-1:0] s1_count_r;
  logic [WID_W-1:0]        s2_width_r;
  logic [PROD_W-1:0]       s3_prod_r;
  logic [DIST_W-1:0]       s4_raw_r;
  logic [SUM_W-1:0]        s5_val_r;
  logic                    out_valid_r;
  out_item_t               out_data_r;

  // accept decode
  logic [CH_AW-1:0]        in_addr;
  logic                    in_rng;
  logic                    in_wait;
  logic                    in_ref, in_first, in_sec;
  tag_t                    in_tag;
  logic [COUNTER_BITS-1:0] in_count;

  // memories
  logic [COUNTER_BITS-1:0] first_rdata;
  logic [ROW_W-1:0]        row_rdata;
  logic [CH_AW-1:0]        s3_addr, s4_addr;
  logic                    row_re, row_we;

  // datapath
  logic [COUNTER_BITS-1:0] s1_diff;
  logic [WID_W-1:0]        s1_width;
  logic [RAW_W-1:0]        s3_raw_full;
  logic [DIST_W-1:0]       s3_raw;
  logic [ROW_W-1:0]        s4_old_row;
  logic [ROW_W-1:0]        s4_new_row;
  logic [SUM_W-1:0]        s4_sum;
  logic [SUM_W-1:0]        s4_val;
  logic [DIV_PW-1:0]       s5_quot_full;
  logic [DIST_W-1:0]       s5_dist;

  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = !adv;
  assign acc       = in_valid && adv;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // --------------------------------------------------------------------------
  // configuration
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_scale_r   <= TICK_SCALE_RST;
      max_distance_r <= MAX_DISTANCE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_e'(cfg_index))
        REG_TICK_SCALE:   tick_scale_r   <= cfg_data[SCALE_W-1:0];
        REG_MAX_DISTANCE: max_distance_r <= cfg_data[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // accept: classify the event and update the per-channel flags at once
  // --------------------------------------------------------------------------
  always_comb begin
    in_addr  = CH_AW'(in_data.channel);
    in_rng   = 32'(in_data.channel) < CHANNELS;
    in_wait  = in_rng && waiting_r[in_addr];
    in_ref   = in_rng && (in_data.command == CMD_REFILL);
    in_first = in_rng && (in_data.command == CMD_EDGE) && !in_wait;
    in_sec   = in_rng && (in_data.command == CMD_EDGE) && in_wait;
    in_count = COUNTER_BITS'(in_data.capture_count);
    in_tag.ch      = in_data.channel;
    in_tag.sec     = in_sec;
    in_tag.refill  = in_sec && pending_r[in_addr];
    in_tag.falling = in_ref ? in_wait : in_first;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      waiting_r <= '0;
      pending_r <= '1;
    end else if (acc) begin
      if (in_ref) begin
        pending_r[in_addr] <= 1'b1;
      end
      if (in_first) begin
        waiting_r[in_addr] <= 1'b1;
      end
      if (in_sec) begin
        waiting_r[in_addr] <= 1'b0;
        pending_r[in_addr] <= 1'b0;
      end
    end
  end

  urea_ram #(
    .WIDTH (COUNTER_BITS),
    .DEPTH (CHANNELS)
  ) u_first_ram (
    .clk   (clk),
    .we    (acc && in_first),
    .waddr (in_addr),
    .wdata (in_count),
    .re    (acc && in_sec),
    .raddr (in_addr),
    .rdata (first_rdata)
  );

  // --------------------------------------------------------------------------
  // pipeline valid bits
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      s5_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_v_r      <= acc;
      s2_v_r      <= s1_v_r;
      s3_v_r      <= s2_v_r;
      s4_v_r      <= s3_v_r;
      s5_v_r      <= s4_v_r;
      out_valid_r <= s5_v_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: pulse width; equal counts mean one full timer period
  // --------------------------------------------------------------------------
  always_comb begin
    s1_diff  = s1_count_r - first_rdata;
    s1_width = (s1_diff == '0) ? {1'b1, {COUNTER_BITS{1'b0}}} : {1'b0, s1_diff};
  end

  // stage 3: drop fraction bits and saturate
  always_comb begin
    s3_raw_full = s3_prod_r[PROD_W-1:FRAC_DROP];
    s3_raw      = (s3_raw_full > RAW_W'(max_distance_r)) ? max_distance_r
                                                          : s3_raw_full[DIST_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_tag_r   <= in_tag;
      s1_count_r <= in_count;
      s2_tag_r   <= s1_tag_r;
      s2_width_r <= s1_width;
      s3_tag_r   <= s2_tag_r;
      s3_prod_r  <= PROD_W'(s2_width_r) * PROD_W'(tick_scale_r);
      s4_tag_r   <= s3_tag_r;
      s4_raw_r   <= s3_raw;
      s5_tag_r   <= s4_tag_r;
      s5_val_r   <= s4_val;
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: window read-modify-write. The read issues as an item enters
  // stage 4 and the write as it leaves, so two second edges of one channel,
  // always at least two transactions apart, never overlap.
  // --------------------------------------------------------------------------
  assign s3_addr = CH_AW'(s3_tag_r.ch);
  assign s4_addr = CH_AW'(s4_tag_r.ch);
  assign row_re  = adv && s3_v_r && s3_tag_r.sec;
  assign row_we  = adv && s4_v_r && s4_tag_r.sec;

  urea_ram #(
    .WIDTH (ROW_W),
    .DEPTH (CHANNELS)
  ) u_window_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (s4_addr),
    .wdata (s4_new_row),
    .re    (row_re),
    .raddr (s3_addr),
    .rdata (row_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
    end else if (row_we) begin
      row_valid_r[s4_addr] <= 1'b1;
    end
  end

  // entry 0 is the oldest; shift it out and append the new distance on top (a refill fills every entry with it)
  always_comb begin
    s4_old_row = row_valid_r[s4_addr] ? row_rdata : '0;
    if (s4_tag_r.refill) begin
      s4_new_row = {WINDOW_DEPTH{s4_raw_r}};
    end else begin
      s4_new_row = {s4_raw_r, s4_old_row[ROW_W-1:DIST_W]};
    end
    s4_sum = '0;
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      s4_sum = s4_sum + SUM_W'(s4_new_row[i*DIST_W +: DIST_W]);
    end
    s4_val = s4_tag_r.refill ? SUM_W'(s4_raw_r) : s4_sum;
  end

  // --------------------------------------------------------------------------
  // stage 5: divide by the window depth through the reciprocal
  // --------------------------------------------------------------------------
  always_comb begin
    s5_quot_full = DIV_PW'(s5_val_r) * DIV_PW'(DIV_MW'(DIV_M));
    if (!s5_tag_r.sec) begin
      s5_dist = '0;
    end else if (s5_tag_r.refill) begin
      s5_dist = s5_val_r[DIST_W-1:0];
    end else begin
      s5_dist = s5_quot_full[DIV_SH +: DIST_W];
    end
  end

  // hold the result while stalled
  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r.out_channel    <= s5_tag_r.ch;
      out_data_r.distance_valid <= s5_tag_r.sec;
      out_data_r.distance       <= s5_dist;
      out_data_r.expect_falling <= s5_tag_r.falling;
    end
  end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - testbench of the ultrasonic echo range averager
// Drives capture edge events and refill requests on six channels (and on the
// two unused channel codes) with bursty traffic and a stalling receiver. Each
// accepted transaction is run through a behavioral copy of the ranger (edge
// pairing, tick scaling, saturation, moving window). Each result is checked
// in order, field by field, under several register settings.
// ----------------------------------------------------------------------------
module tb_top;
  import urea_pkg::*;

  localparam int IDLE_LIMIT = 1000;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_BURSTS
  } stall_mode_e;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // behavioral copy of the ranger state
  logic [SCALE_W-1:0]  tick_scale_q = TICK_SCALE_RST;
  logic [DIST_W-1:0]   max_dist_q = MAX_DISTANCE_RST;
  logic                second_due [CHANNELS] = '{default: 1'b0};
  logic [CNT_IN_W-1:0] first_stamp [CHANNELS] = '{default: '0};
  logic                refill_due [CHANNELS] = '{default: 1'b1};
  logic [DIST_W-1:0]   avg_rows [CHANNELS][WINDOW_DEPTH] = '{default: '{default: '0}};

  out_item_t           pending_ranges[$];
  out_item_t           want_range;
  int                  mismatches = 0;

  // stimulus side view of the edge pairing
  logic                stim_waiting [CHANNELS] = '{default: 1'b0};
  logic [CNT_IN_W-1:0] stim_first [CHANNELS] = '{default: '0};
  int                  burst_left = 0;
  logic                calm = 1'b0;

  stall_mode_e         stall_mode = STALL_NONE;
  logic [5:0]          stall_phase = '0;
  int                  idle_cycles = 0;

  ultrasonic_echo_range_averager_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic out_item_t predict_range(input in_item_t item);
    out_item_t         res;
    logic [16:0]       now_cnt;
    logic [16:0]       then_cnt;
    logic [16:0]       width;
    logic [48:0]       product;
    logic [32:0]       raw;
    logic [DIST_W-1:0] clipped;
    logic [DIST_W+7:0] sum;
    int                ch;
    res = '0;
    res.out_channel = item.channel;
    if (item.channel < CHANNELS) begin
      ch = item.channel;
      if (item.command == CMD_REFILL) begin
        refill_due[ch] = 1'b1;
        res.expect_falling = second_due[ch];
      end else if (!second_due[ch]) begin
        first_stamp[ch] = item.capture_count;
        second_due[ch] = 1'b1;
        res.expect_falling = 1'b1;
      end else begin
        now_cnt = {1'b0, item.capture_count};
        then_cnt = {1'b0, first_stamp[ch]};
        // equal or lower count means the timer wrapped
        width = (now_cnt > then_cnt) ? now_cnt - then_cnt
                                     : now_cnt + (17'd1 << COUNTER_BITS) - then_cnt;
        product = 49'(width) * 49'(tick_scale_q);
        raw = product[48:16];
        clipped = (raw > 33'(max_dist_q)) ? max_dist_q : raw[DIST_W-1:0];
        if (refill_due[ch]) begin
          for (int k = 0; k < WINDOW_DEPTH; k++) avg_rows[ch][k] = clipped;
          refill_due[ch] = 1'b0;
          res.distance = clipped;
        end else begin
          sum = '0;
          for (int k = 1; k < WINDOW_DEPTH; k++) avg_rows[ch][k-1] = avg_rows[ch][k];
          avg_rows[ch][WINDOW_DEPTH-1] = clipped;
          for (int k = 0; k < WINDOW_DEPTH; k++) sum += avg_rows[ch][k];
          res.distance = DIST_W'(sum / WINDOW_DEPTH);
        end
        res.distance_valid = 1'b1;
        second_due[ch] = 1'b0;
        res.expect_falling = 1'b0;
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint got_v, input longint want_v);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got_v, want_v, $time);
    mismatches++;
  endtask

  // predict on every accepted input transaction
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) pending_ranges.push_back(predict_range(in_data));
  end

  // check every accepted result transaction against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_ranges.size() == 0) begin
        report_mismatch("unexpected result, channel", out_data.out_channel, -1);
      end else begin
        want_range = pending_ranges.pop_front();
        if (out_data.out_channel !== want_range.out_channel)
          report_mismatch("out_channel", out_data.out_channel, want_range.out_channel);
        if (out_data.distance_valid !== want_range.distance_valid)
          report_mismatch("distance_valid", out_data.distance_valid,
                          want_range.distance_valid);
        if (out_data.distance !== want_range.distance)
          report_mismatch("distance", out_data.distance, want_range.distance);
        if (out_data.expect_falling !== want_range.expect_falling)
          report_mismatch("expect_falling", out_data.expect_falling,
                          want_range.expect_falling);
      end
    end
  end

  // receiver: switch stall pattern each time the 6-bit phase counter wraps
  always @(posedge clk) begin
    stall_phase <= stall_phase + 6'd1;
    if (stall_phase == '0) stall_mode <= stall_mode_e'($urandom_range(0, 3));
    if (!rst_n || calm) begin
      out_stall <= 1'b0;
    end else begin
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= stall_phase[3];
      endcase
    end
  end

  initial begin : watchdog
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic send_event(input logic cmd, input logic [CH_W-1:0] ch,
                            input logic [CNT_IN_W-1:0] cnt);
    in_item_t item;
    int       gap;
    item.command = cmd;
    item.channel = ch;
    item.capture_count = cnt;
    if (ch < CHANNELS && cmd == CMD_EDGE) begin
      if (!stim_waiting[ch]) stim_first[ch] = cnt;
      stim_waiting[ch] = !stim_waiting[ch];
    end
    if (burst_left == 0) begin
      gap = calm ? 0 : $urandom_range(0, 12);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
  endtask

  // hold input until all results are back, then let the pipeline settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_ranges.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_TICK_SCALE) tick_scale_q = value;
    else max_dist_q = value[DIST_W-1:0];
  endtask

  task automatic random_event();
    int                  pick;
    logic [CH_W-1:0]     ch;
    logic [CNT_IN_W-1:0] cnt;
    pick = $urandom_range(0, 99);
    ch = CH_W'($urandom_range(0, CHANNELS - 1));
    cnt = CNT_IN_W'($urandom());
    if (pick < 5) begin
      send_event(1'($urandom_range(0, 1)), CH_W'($urandom_range(CHANNELS, 7)), cnt);
    end else if (pick < 12) begin
      send_event(CMD_REFILL, ch, cnt);
    end else if (!stim_waiting[ch]) begin
      send_event(CMD_EDGE, ch, cnt);
    end else begin
      // shape the echo width: mostly in the ranging span, some wraps
      case ($urandom_range(0, 9))
        0:       cnt = CNT_IN_W'($urandom());
        1:       cnt = stim_first[ch];
        2:       cnt = stim_first[ch] - CNT_IN_W'($urandom_range(1, 4));
        default: cnt = stim_first[ch] + CNT_IN_W'($urandom_range(1, 20000));
      endcase
      send_event(CMD_EDGE, ch, cnt);
    end
  endtask

  task automatic test_directed_events();
    send_event(CMD_REFILL, 3'd0, 16'h0000);
    send_event(CMD_EDGE,   3'd0, 16'h0000);
    send_event(CMD_EDGE,   3'd0, 16'h0000);
    send_event(CMD_EDGE,   3'd1, 16'd100);
    send_event(CMD_REFILL, 3'd1, 16'hFFFF);
    send_event(CMD_EDGE,   3'd1, 16'd101);
    send_event(CMD_EDGE,   3'd2, 16'hFFFF);
    send_event(CMD_EDGE,   3'd2, 16'h0000);
    send_event(CMD_EDGE,   3'd3, 16'h0000);
    send_event(CMD_EDGE,   3'd3, 16'hFFFF);
    send_event(CMD_EDGE,   3'd4, 16'hAAAA);
    send_event(CMD_EDGE,   3'd4, 16'h5555);
    send_event(CMD_EDGE,   3'd5, 16'h5555);
    send_event(CMD_EDGE,   3'd5, 16'hAAAA);
    send_event(CMD_EDGE,   3'd6, 16'hFFFF);
    send_event(CMD_REFILL, 3'd7, 16'hFFFF);
    send_event(CMD_EDGE,   3'd7, 16'h0000);
    send_event(CMD_EDGE,   3'd1, 16'd200);
    send_event(CMD_EDGE,   3'd1, 16'd3200);
    send_event(CMD_EDGE,   3'd1, 16'd500);
    send_event(CMD_EDGE,   3'd1, 16'd20500);
    send_event(CMD_EDGE,   3'd5, 16'd10);
    send_event(CMD_EDGE,   3'd5, 16'd10);
    wait_idle();
  endtask

  task automatic test_register_extremes();
    logic [SCALE_W-1:0] scales [4];
    logic [DIST_W-1:0]  limits [4];
    scales = '{32'd1, 32'hFFFF_FFFF, 32'd0, TICK_SCALE_RST};
    limits = '{18'd0, 18'h3FFFF, MAX_DISTANCE_RST, 18'h3FFFF};
    for (int s = 0; s < 4; s++) begin
      write_reg(REG_TICK_SCALE, scales[s]);
      write_reg(REG_MAX_DISTANCE, CFG_DATA_W'(limits[s]));
      repeat (60) random_event();
      wait_idle();
    end
  endtask

  task automatic test_random_traffic();
    for (int p = 0; p < 5; p++) begin
      if (p == 0) begin
        write_reg(REG_TICK_SCALE, TICK_SCALE_RST);
        write_reg(REG_MAX_DISTANCE, CFG_DATA_W'(MAX_DISTANCE_RST));
      end else begin
        write_reg(REG_TICK_SCALE, ($urandom_range(0, 3) == 0) ? $urandom()
                                                              : $urandom_range(1, 2000000));
        write_reg(REG_MAX_DISTANCE, $urandom_range(0, 262143));
      end
      calm = ($urandom_range(0, 3) == 0);
      repeat (250) random_event();
      wait_idle();
      calm = 1'b0;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_events();
    test_register_extremes();
    test_random_traffic();
    if (pending_ranges.size() != 0)
      report_mismatch("results left outstanding", 0, pending_ranges.size());
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
